FILE: sv/nsfe_pkg.sv
// ---------------------------------------------------------------------------
// nsfe_pkg
// shared types, codes and helpers for the sentence field extractor
// ---------------------------------------------------------------------------
`default_nettype none

package nsfe_pkg;

   localparam int FIELD_CHARS  = 16;
   localparam int HEADER_CHARS = 8;

   localparam int BYTE_W      = 8;
   localparam int FIELD_W     = 4;
   localparam int POS_W       = $clog2(FIELD_CHARS);
   localparam int CHAR_CNT_W  = $clog2(FIELD_CHARS + 1);
   localparam int HDR_CNT_W   = $clog2(HEADER_CHARS + 1);
   localparam int CSR_INDEX_W = 2;

   localparam int RSP_FIELDS_W = 2 + 2 + FIELD_W + POS_W + BYTE_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [FIELD_W-1:0] FIELD_MAX = 4'd15;

   // register map
   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEP_BYTE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_BYTE   = 2'd2;

   localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'd36;
   localparam logic [BYTE_W-1:0] SEP_BYTE_RESET   = 8'd44;
   localparam logic [BYTE_W-1:0] END_BYTE_RESET   = 8'd42;

   typedef enum logic [1:0] {
      ACT_STORE = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_END   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      KIND_GGA  = 2'd0,
      KIND_RMC  = 2'd1,
      KIND_VTG  = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  char_value;
      logic [POS_W-1:0]   char_position;
      logic [FIELD_W-1:0] field_number;
      kind_type           sentence_kind;
      action_type         action;
   } rsp_type;

   // sentence kind from header bytes 3 to 5
   function automatic kind_type kind_of(input logic [BYTE_W-1:0] a,
                                        input logic [BYTE_W-1:0] b,
                                        input logic [BYTE_W-1:0] c);
      kind_type k;
      k = KIND_NONE;
      if (a == "G" && b == "G" && c == "A") k = KIND_GGA;
      else if (a == "R" && b == "M" && c == "C") k = KIND_RMC;
      else if (a == "V" && b == "T" && c == "G") k = KIND_VTG;
      return k;
   endfunction

   function automatic logic [FIELD_W-1:0] fields_of(input kind_type k);
      logic [FIELD_W-1:0] n;
      unique case (k)
         KIND_GGA: n = 4'd14;
         KIND_RMC: n = 4'd12;
         KIND_VTG: n = 4'd9;
         default:  n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: sv/nmea_sentence_field_extractor_unit.sv
// ---------------------------------------------------------------------------
// nmea_sentence_field_extractor_unit
// splits a received character stream into field clear, store and end records
// ---------------------------------------------------------------------------
// usage:
//   req_* carries one received byte per beat. the byte is parsed at the edge
//   it is accepted, and the record it causes (if any) lands in the output
//   register, shown on rsp_* from the next cycle on.
//   throughput is one byte per cycle while the receiver does not stall,
//   set by the single parser update between the input port and the output
//   register.
//   many bytes (idle noise, header bytes, overflow bytes) give no record.
//   when the receiver stalls, the held record stays on rsp_*; req_tready
//   stays high as long as the output register is empty or being taken in
//   the same cycle, so a stall costs one beat of buffering and then
//   backpressures the input.
//   csr_* writes the start, separator and end byte values (index 0, 1, 2);
//   other indexes are ignored. write only while the block is idle.
//   reset (synchronous, active high) returns the parser to waiting for a
//   start byte, restores the default byte values and empties the output.
// ---------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_field_extractor_unit
   import nsfe_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,

   input  wire logic                    req_tvalid,
   output      logic                    req_tready,
   input  wire logic [BYTE_W-1:0]       req_tdata,   // [7:0] rx_byte

   output      logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   // [1:0] action, [3:2] sentence_kind, [7:4] field_number,
   // [11:8] char_position, [19:12] char_value, upper bits zero
   output      logic [RSP_DATA_W-1:0]   rsp_tdata,

   input  wire logic                    csr_valid,
   output      logic                    csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [BYTE_W-1:0]       csr_data
);

   // configuration registers
   logic [BYTE_W-1:0] start_byte_ff;
   logic [BYTE_W-1:0] sep_byte_ff;
   logic [BYTE_W-1:0] end_byte_ff;

   // parser state; only header bytes 3 to 5 are ever looked at
   logic                  in_sentence_ff, in_sentence_in;
   logic [BYTE_W-1:0]     hdr3_ff, hdr3_in;
   logic [BYTE_W-1:0]     hdr4_ff, hdr4_in;
   logic [BYTE_W-1:0]     hdr5_ff, hdr5_in;
   logic [HDR_CNT_W-1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [FIELD_W-1:0]    field_cnt_ff, field_cnt_in;
   logic [CHAR_CNT_W-1:0] char_cnt_ff, char_cnt_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic               req_accept;
   logic               emit;
   kind_type           kind;
   logic [FIELD_W-1:0] kind_fields;
   logic [FIELD_W-1:0] field_next;
   logic [HDR_CNT_W-1:0] hdr_cnt_inc;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, rsp_ff};

   assign kind        = kind_of(hdr3_ff, hdr4_ff, hdr5_ff);
   assign kind_fields = fields_of(kind);
   assign field_next  = (field_cnt_ff < FIELD_MAX) ? field_cnt_ff + 1'b1 : field_cnt_ff;
   assign hdr_cnt_inc = hdr_cnt_ff + 1'b1;

   // parser update for one accepted byte
   always_comb begin
      in_sentence_in = in_sentence_ff;
      hdr3_in        = hdr3_ff;
      hdr4_in        = hdr4_ff;
      hdr5_in        = hdr5_ff;
      hdr_cnt_in     = hdr_cnt_ff;
      field_cnt_in   = field_cnt_ff;
      char_cnt_in    = char_cnt_ff;
      emit           = 1'b0;
      rsp_in.action        = ACT_STORE;
      rsp_in.sentence_kind = kind;
      rsp_in.field_number  = '0;
      rsp_in.char_position = '0;
      rsp_in.char_value    = '0;

      if (req_accept) begin
         if (!in_sentence_ff) begin
            // start byte is header byte 0, nothing else matters while idle
            if (req_tdata == start_byte_ff) begin
               in_sentence_in = 1'b1;
               hdr_cnt_in     = HDR_CNT_W'(1);
            end
         end else if (req_tdata == end_byte_ff) begin
            emit           = 1'b1;
            rsp_in.action  = ACT_END;
            in_sentence_in = 1'b0;
            hdr3_in        = '0;
            hdr4_in        = '0;
            hdr5_in        = '0;
            hdr_cnt_in     = '0;
            field_cnt_in   = '0;
            char_cnt_in    = '0;
         end else if (req_tdata == sep_byte_ff) begin
            field_cnt_in = field_next;
            char_cnt_in  = '0;
            if (field_next != '0 && field_next <= kind_fields) begin
               emit                = 1'b1;
               rsp_in.action       = ACT_CLEAR;
               rsp_in.field_number = field_next;
            end
         end else if (field_cnt_ff == '0) begin
            // header byte
            if (hdr_cnt_ff == HDR_CNT_W'(3)) hdr3_in = req_tdata;
            if (hdr_cnt_ff == HDR_CNT_W'(4)) hdr4_in = req_tdata;
            if (hdr_cnt_ff == HDR_CNT_W'(5)) hdr5_in = req_tdata;
            hdr_cnt_in = hdr_cnt_inc;
            // header too long: drop the sentence
            if (hdr_cnt_inc >= HDR_CNT_W'(HEADER_CHARS)) begin
               in_sentence_in = 1'b0;
               hdr3_in        = '0;
               hdr4_in        = '0;
               hdr5_in        = '0;
               hdr_cnt_in     = '0;
               field_cnt_in   = '0;
               char_cnt_in    = '0;
            end
         end else if (field_cnt_ff <= kind_fields &&
                      char_cnt_ff < CHAR_CNT_W'(FIELD_CHARS)) begin
            emit                 = 1'b1;
            rsp_in.action        = ACT_STORE;
            rsp_in.field_number  = field_cnt_ff;
            rsp_in.char_position = char_cnt_ff[POS_W-1:0];
            rsp_in.char_value    = req_tdata;
            char_cnt_in          = char_cnt_ff + 1'b1;
         end
      end
   end

   // output register: load on a new record, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= START_BYTE_RESET;
         sep_byte_ff    <= SEP_BYTE_RESET;
         end_byte_ff    <= END_BYTE_RESET;
         in_sentence_ff <= 1'b0;
         hdr3_ff        <= '0;
         hdr4_ff        <= '0;
         hdr5_ff        <= '0;
         hdr_cnt_ff     <= '0;
         field_cnt_ff   <= '0;
         char_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_START_BYTE: start_byte_ff <= csr_data;
               CSR_SEP_BYTE:   sep_byte_ff   <= csr_data;
               CSR_END_BYTE:   end_byte_ff   <= csr_data;
               default: ;
            endcase
         end
         in_sentence_ff <= in_sentence_in;
         hdr3_ff        <= hdr3_in;
         hdr4_ff        <= hdr4_in;
         hdr5_ff        <= hdr5_in;
         hdr_cnt_ff     <= hdr_cnt_in;
         field_cnt_ff   <= field_cnt_in;
         char_cnt_ff    <= char_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // record payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
